[rtl/pls_pkg.sv]
// Shared types and constants for the positional list stack.
// Used by the controller, the top level and the port checker; no dependencies.
package pls_pkg;

  localparam int DEPTH  = 64;
  localparam int ITEM_W = 8;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int POS_W  = 7;
  localparam int CAP_W  = 7;
  localparam int OP_W   = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(52);

  // Operation codes carried on op_i
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_READ    = 3'd3,
    OP_INSERT  = 3'd4,
    OP_REMOVE  = 3'd5,
    OP_REVERSE = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Request from the controller to the entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ITEM_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/pls_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module pls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read of the entry being written returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pls_ctrl.sv]
// Operation sequencer for the positional list stack: decodes an item, walks the
// entry store for shifts and swaps, and holds the result register. Uses pls_pkg.
module pls_ctrl import pls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [ITEM_W-1:0] item_in_i,
  input  logic [CAP_W-1:0]  cap_i,
  output mem_req_t          mem_o,
  input  logic [ITEM_W-1:0] mem_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ITEM_W-1:0] item_out_o,
  output logic [CNT_W-1:0]  count_now_o,
  output logic [1:0]        status_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_INS,
    S_INS_LAST,
    S_INS_PUT,
    S_REM,
    S_REM_LAST,
    S_REV_A,
    S_REV_B,
    S_REV_DA,
    S_REV_DB,
    S_RESULT
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  op_e               op_q, op_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ITEM_W-1:0] item_q, item_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;   // read pointer, low end for reverse
  logic [ADDR_W-1:0] hi_q, hi_d;           // high end for reverse
  logic [ADDR_W-1:0] wa_q, wa_d;           // pending write address
  logic [ADDR_W-1:0] wb_q, wb_d;           // pending high write address (reverse)
  logic              wpend_q, wpend_d;
  logic [ITEM_W-1:0] tmp_q, tmp_d;
  logic [ITEM_W-1:0] res_item_q, res_item_d;
  status_e           res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  logic [ITEM_W-1:0] out_item_q, out_item_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  status_e           out_st_q, out_st_d;

  logic [CNT_W-1:0]  limit;
  logic              full;
  op_e               op_in;

  assign op_in = op_e'(op_i);

  // Effective entry limit: capacity clipped to the store depth
  assign limit = (cap_i > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_i);
  assign full  = (count_q >= limit) || (count_q >= CNT_W'(DEPTH));

  // Next-state and store access
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    op_d        = op_q;
    pos_d       = pos_q;
    item_d      = item_q;
    rd_ptr_d    = rd_ptr_q;
    hi_d        = hi_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wpend_d     = wpend_q;
    tmp_d       = tmp_q;
    res_item_d  = res_item_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    out_count_d = out_count_q;
    out_st_d    = out_st_q;
    mem_o       = '0;
    mem_o.raddr = rd_ptr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        // Read issued up front for pop, peek, read_at and remove_at
        if (op_in == OP_POP || op_in == OP_PEEK) begin
          mem_o.raddr = ADDR_W'(count_q - 1'b1);
        end else begin
          mem_o.raddr = position_i[ADDR_W-1:0];
        end
        if (in_valid_i) begin
          op_d       = op_in;
          pos_d      = position_i[ADDR_W-1:0];
          item_d     = item_in_i;
          res_item_d = '0;
          res_st_d   = ST_OK;
          state_d    = S_RESULT;
          unique case (op_in)
            OP_PUSH: begin
              if (full) begin
                res_st_d = ST_FULL;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = count_q[ADDR_W-1:0];
                mem_o.wdata = item_in_i;
                count_d     = count_q + 1'b1;
              end
            end
            OP_INSERT: begin
              priority if (full) begin
                res_st_d = ST_FULL;
              end else if (position_i > count_q) begin
                res_st_d = ST_BADPOS;
              end else if (position_i == count_q) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = position_i[ADDR_W-1:0];
                mem_o.wdata = item_in_i;
                count_d     = count_q + 1'b1;
              end else begin
                rd_ptr_d = ADDR_W'(count_q - 1'b1);
                wpend_d  = 1'b0;
                state_d  = S_INS;
              end
            end
            OP_POP, OP_PEEK: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
              end else begin
                state_d = S_READ;
              end
            end
            OP_READ, OP_REMOVE: begin
              if (position_i >= count_q) begin
                res_st_d = ST_BADPOS;
              end else begin
                state_d = S_READ;
              end
            end
            OP_REVERSE: begin
              if (count_q > CNT_W'(1)) begin
                rd_ptr_d = '0;
                hi_d     = ADDR_W'(count_q - 1'b1);
                wpend_d  = 1'b0;
                state_d  = S_REV_A;
              end
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      // Read data back; pop drops the top, remove drops the top entry or starts shifting down
      S_READ: begin
        res_item_d = mem_rdata_i;
        state_d    = S_RESULT;
        if (op_q == OP_POP) begin
          count_d = count_q - 1'b1;
        end else if (op_q == OP_REMOVE) begin
          if (CNT_W'(pos_q) + 1'b1 >= count_q) begin
            count_d = count_q - 1'b1;
          end else begin
            rd_ptr_d = pos_q + 1'b1;
            wpend_d  = 1'b0;
            state_d  = S_REM;
          end
        end
      end

      // Shift up: read entry i, write it to i+1 in the next cycle
      S_INS: begin
        mem_o.raddr = rd_ptr_q;
        if (wpend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wa_q;
          mem_o.wdata = mem_rdata_i;
        end
        wa_d    = rd_ptr_q + 1'b1;
        wpend_d = 1'b1;
        if (rd_ptr_q == pos_q) begin
          state_d = S_INS_LAST;
        end else begin
          rd_ptr_d = rd_ptr_q - 1'b1;
        end
      end

      S_INS_LAST: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wa_q;
        mem_o.wdata = mem_rdata_i;
        state_d     = S_INS_PUT;
      end

      S_INS_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = item_q;
        count_d     = count_q + 1'b1;
        state_d     = S_RESULT;
      end

      // Shift down: read entry i, write it to i-1 in the next cycle
      S_REM: begin
        mem_o.raddr = rd_ptr_q;
        if (wpend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wa_q;
          mem_o.wdata = mem_rdata_i;
        end
        wa_d    = rd_ptr_q - 1'b1;
        wpend_d = 1'b1;
        if (CNT_W'(rd_ptr_q) + 1'b1 == count_q) begin
          state_d = S_REM_LAST;
        end else begin
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
      end

      S_REM_LAST: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wa_q;
        mem_o.wdata = mem_rdata_i;
        count_d     = count_q - 1'b1;
        state_d     = S_RESULT;
      end

      // Reverse by pairs, S_REV_A then S_REV_B: the writes of one pair overlap the reads of the next
      S_REV_A: begin
        mem_o.raddr = rd_ptr_q;
        if (wpend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wa_q;
          mem_o.wdata = mem_rdata_i;
        end
        state_d = S_REV_B;
      end

      S_REV_B: begin
        mem_o.raddr = hi_q;
        if (wpend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wb_q;
          mem_o.wdata = tmp_q;
        end
        tmp_d    = mem_rdata_i;
        wa_d     = rd_ptr_q;
        wb_d     = hi_q;
        wpend_d  = 1'b1;
        rd_ptr_d = rd_ptr_q + 1'b1;
        hi_d     = hi_q - 1'b1;
        if (CNT_W'(rd_ptr_q) + CNT_W'(2) < CNT_W'(hi_q)) begin
          state_d = S_REV_A;
        end else begin
          state_d = S_REV_DA;
        end
      end

      S_REV_DA: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wa_q;
        mem_o.wdata = mem_rdata_i;
        state_d     = S_REV_DB;
      end

      S_REV_DB: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wb_q;
        mem_o.wdata = tmp_q;
        state_d     = S_RESULT;
      end

      // Hand the result to the output register once it is free
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_item_d  = res_item_q;
          out_count_d = count_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      op_q        <= OP_NOP;
      pos_q       <= '0;
      item_q      <= '0;
      rd_ptr_q    <= '0;
      hi_q        <= '0;
      wa_q        <= '0;
      wb_q        <= '0;
      wpend_q     <= 1'b0;
      tmp_q       <= '0;
      res_item_q  <= '0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      out_count_q <= '0;
      out_st_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      op_q        <= op_d;
      pos_q       <= pos_d;
      item_q      <= item_d;
      rd_ptr_q    <= rd_ptr_d;
      hi_q        <= hi_d;
      wa_q        <= wa_d;
      wb_q        <= wb_d;
      wpend_q     <= wpend_d;
      tmp_q       <= tmp_d;
      res_item_q  <= res_item_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
      out_count_q <= out_count_d;
      out_st_q    <= out_st_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign item_out_o  = out_item_q;
  assign count_now_o = out_count_q;
  assign status_o    = out_st_q;

endmodule

[rtl/positional_list_stack.sv]
// Flow: push, errors and no-op go straight to the result; pop, peek and read_at read the
// store first; insert_at shifts up from the position (not when appending on top);
// remove_at shifts the entries above down (not for the top one); reverse swaps pairs.
// One item at a time: the next item is taken once the sequencer is back in idle,
// set by the one read and one write port of the entry store per cycle.
// Reset: count cleared, capacity set to 52, output empty; the store is not cleared.
// Top level: capacity register, entry store and sequencer. Uses pls_pkg, pls_ram, pls_ctrl.
module positional_list_stack import pls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [ITEM_W-1:0] item_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ITEM_W-1:0] item_out_o,
  output logic [CNT_W-1:0]  count_now_o,
  output logic [1:0]        status_o
);

  logic [CAP_W-1:0]  cap_q;
  mem_req_t          mem_req;
  logic [ITEM_W-1:0] mem_rdata;

  // Capacity register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Entry store
  pls_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(mem_rdata)
  );

  // Operation sequencer
  pls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .position_i (position_i),
    .item_in_i  (item_in_i),
    .cap_i      (cap_q),
    .mem_o      (mem_req),
    .mem_rdata_i(mem_rdata),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .item_out_o (item_out_o),
    .count_now_o(count_now_o),
    .status_o   (status_o)
  );

endmodule

[rtl/pls_checker.sv]
// Port-level checks for positional_list_stack, attached by bind.
// Uses pls_pkg.
module pls_checker import pls_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [CAP_W-1:0]  cfg_data_i,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [OP_W-1:0]   op_i,
  input logic [POS_W-1:0]  position_i,
  input logic [ITEM_W-1:0] item_in_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ITEM_W-1:0] item_out_o,
  input logic [CNT_W-1:0]  count_now_o,
  input logic [1:0]        status_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(item_out_o) && $stable(count_now_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Any error returns a zero item
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> item_out_o == '0)
    else $error("nonzero item on error");

  // Empty is only reported with no entries
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> count_now_o == '0)
    else $error("empty status with entries present");

  // The count never exceeds the store depth
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_now_o <= CNT_W'(DEPTH))
    else $error("count above depth");

  // The block is never ready again straight after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken back to back");

endmodule

bind positional_list_stack pls_checker u_pls_checker (.*);

[tb/pls_list_checker.sv]
`timescale 1ns / 1ps
// Result checker for the positional list stack: mirrors the list, predicts each result
// and compares it with what the block returns. Depends on pls_pkg only.
module pls_list_checker import pls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [ITEM_W-1:0] item_in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ITEM_W-1:0] item_out_i,
  input  logic [CNT_W-1:0]  count_now_i,
  input  logic [1:0]        status_i,
  output int                pending_o,
  output int                fill_o,
  output int                fail_count_o
);

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic [CNT_W-1:0]  count;
    status_e           status;
  } list_result_t;

  // Mirror of the list contents, length and capacity register
  logic [ITEM_W-1:0] shadow_store [DEPTH];
  int unsigned       shadow_fill;
  int unsigned       shadow_cap;

  list_result_t awaited_results [$];
  int           fail_count = 0;

  assign fail_count_o = fail_count;

  // Apply one operation to the mirror and return the result it should produce
  function automatic list_result_t apply_list_op(input op_e op, input int unsigned pos,
                                                 input logic [ITEM_W-1:0] val);
    list_result_t r;
    int unsigned  limit;
    int unsigned  at;
    int unsigned  lo;
    int unsigned  hi;
    logic [ITEM_W-1:0] tmp;
    r.item   = '0;
    r.status = ST_OK;
    limit    = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    at       = pos;
    case (op)
      OP_PUSH, OP_INSERT: begin
        if (op == OP_PUSH) at = shadow_fill;
        // full wins over a bad position
        if (shadow_fill >= limit) r.status = ST_FULL;
        else if (at > shadow_fill) r.status = ST_BADPOS;
        else begin
          for (int i = shadow_fill; i > at; i--) shadow_store[i] = shadow_store[i-1];
          shadow_store[at] = val;
          shadow_fill++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else begin
          r.item = shadow_store[shadow_fill-1];
          if (op == OP_POP) shadow_fill--;
        end
      end
      OP_READ, OP_REMOVE: begin
        if (at >= shadow_fill) r.status = ST_BADPOS;
        else begin
          r.item = shadow_store[at];
          if (op == OP_REMOVE) begin
            for (int i = at; i + 1 < shadow_fill; i++) shadow_store[i] = shadow_store[i+1];
            shadow_fill--;
          end
        end
      end
      OP_REVERSE: begin
        if (shadow_fill > 1) begin
          lo = 0;
          hi = shadow_fill - 1;
          while (lo < hi) begin
            tmp              = shadow_store[lo];
            shadow_store[lo] = shadow_store[hi];
            shadow_store[hi] = tmp;
            lo++;
            hi--;
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_fill);
    return r;
  endfunction

  // Watch all three channels; results are checked before the new item is queued
  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      shadow_cap  = CAP_RESET;
      awaited_results.delete();
      pending_o <= 0;
      fill_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result item with nothing awaited: item_out %0h count_now %0d status %0d",
                 item_out_i, count_now_i, status_i);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (item_out_i !== want.item) begin
            $error("item_out mismatch: expected %0h, actual %0h", want.item, item_out_i);
            fail_count++;
          end
          if (count_now_i !== want.count) begin
            $error("count_now mismatch: expected %0d, actual %0d", want.count, count_now_i);
            fail_count++;
          end
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_i);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) shadow_cap = cfg_data_i;
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(apply_list_op(op_e'(op_i), position_i, item_in_i));
      pending_o <= awaited_results.size();
      fill_o    <= shadow_fill;
    end
  end

endmodule

[tb/tb_positional_list_stack.sv]
`timescale 1ns / 1ps
// Top of the positional list stack testbench: clock, reset, directed and random items,
// capacity writes and the verdict. Depends on pls_pkg, the block and pls_list_checker.
module tb_positional_list_stack;
  import pls_pkg::*;

  typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_MIX} lean_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CAP_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic [OP_W-1:0]   op_in     = '0;
  logic [POS_W-1:0]  pos_in    = '0;
  logic [ITEM_W-1:0] item_in   = '0;
  logic              out_ready = 1'b0;

  logic              cfg_ready;
  logic              in_ready;
  logic              out_valid;
  logic [ITEM_W-1:0] item_out;
  logic [CNT_W-1:0]  count_now;
  logic [1:0]        status;

  int pending;
  int list_len;
  int fail_count;

  // Idle rates in percent for the sender and the receiver
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  positional_list_stack dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op_in),
    .position_i  (pos_in),
    .item_in_i   (item_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .item_out_o  (item_out),
    .count_now_o (count_now),
    .status_o    (status)
  );

  pls_list_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op_in),
    .position_i   (pos_in),
    .item_in_i    (item_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .item_out_i   (item_out),
    .count_now_i  (count_now),
    .status_i     (status),
    .pending_o    (pending),
    .fill_o       (list_len),
    .fail_count_o (fail_count)
  );

  // Receiver stalls at random
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Offer one item, with random gaps ahead of it, and wait for it to be taken
  task automatic send_op(input op_e op, input int unsigned pos, input int unsigned val);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_in    <= op;
    pos_in   <= POS_W'(pos);
    item_in  <= ITEM_W'(val);
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Let every awaited result drain before touching the register or ending
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_capacity(input int unsigned cap);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= CAP_W'(cap);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Weighted op choice; weights in op code order, push through no-op
  function automatic op_e pick_op(input lean_e lean);
    int unsigned r;
    int unsigned c;
    int unsigned w [8];
    r = $urandom_range(99);
    case (lean)
      LEAN_GROW:   w = '{55, 5, 3, 4, 25, 5, 2, 1};
      LEAN_SHRINK: w = '{5, 35, 4, 7, 5, 35, 8, 1};
      default:     w = '{20, 14, 8, 14, 18, 14, 8, 4};
    endcase
    c = 0;
    for (int i = 0; i < 8; i++) begin
      c += w[i];
      if (r < c) return op_e'(i);
    end
    return OP_NOP;
  endfunction

  // Mostly in-range positions against the current length, some anywhere in the field
  task automatic random_burst(input lean_e lean, input int unsigned n);
    op_e         op;
    int unsigned pos;
    for (int k = 0; k < n; k++) begin
      op = pick_op(lean);
      if ($urandom_range(9) == 0) pos = $urandom_range(127);
      else begin
        case (op)
          OP_INSERT:          pos = $urandom_range(list_len);
          OP_READ, OP_REMOVE: pos = (list_len > 0) ? $urandom_range(list_len - 1) : 0;
          default:            pos = $urandom_range(127);
        endcase
      end
      send_op(op, pos, $urandom_range(255));
    end
  endtask

  // One capacity setting: a filling burst first, then bursts of random lean
  task automatic run_segment(input int unsigned cap, input int unsigned total);
    int unsigned done;
    int unsigned n;
    write_capacity(cap);
    n = (total < 70) ? total : 70;
    random_burst(LEAN_GROW, n);
    done = n;
    while (done < total) begin
      n = $urandom_range(15, 45);
      if (n > total - done) n = total - done;
      random_burst(lean_e'($urandom_range(2)), n);
      done += n;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 16;
    recv_idle = 88;

    // Empty list corner cases
    send_op(OP_POP, 0, 8'h00);
    send_op(OP_PEEK, 0, 8'h00);
    send_op(OP_READ, 0, 8'h00);
    send_op(OP_REMOVE, 127, 8'hff);
    send_op(OP_REVERSE, 0, 8'h00);
    send_op(OP_NOP, 127, 8'hff);
    send_op(OP_INSERT, 1, 8'h33);
    // Build a few entries, append at the top by position, reverse and take out
    send_op(OP_INSERT, 0, 8'hff);
    send_op(OP_PUSH, 0, 8'h00);
    send_op(OP_PUSH, 0, 8'ha5);
    send_op(OP_PEEK, 0, 8'h00);
    send_op(OP_READ, 1, 8'h00);
    send_op(OP_INSERT, 3, 8'h5a);
    send_op(OP_INSERT, 0, 8'h11);
    send_op(OP_REVERSE, 0, 8'h00);
    send_op(OP_REMOVE, 2, 8'h00);
    send_op(OP_READ, 64, 8'h00);
    send_op(OP_POP, 0, 8'h00);
    // Capacity dropped below the current length
    write_capacity(2);
    send_op(OP_PUSH, 0, 8'h77);
    send_op(OP_INSERT, 127, 8'h77);
    send_op(OP_REMOVE, 0, 8'h00);
    send_op(OP_PUSH, 0, 8'h66);
    // Zero capacity
    write_capacity(0);
    send_op(OP_INSERT, 0, 8'h55);
    send_op(OP_POP, 0, 8'h00);

    // Random part over several capacities and idle profiles
    run_segment(127, 140);
    run_segment(1, 100);
    send_idle = 88;
    recv_idle = 16;
    run_segment(64, 140);
    run_segment($urandom_range(3, 20), 110);
    send_idle = 0;
    recv_idle = 0;
    run_segment(0, 80);
    run_segment(40, 130);

    drain_results();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_ctrl.sv
rtl/positional_list_stack.sv
rtl/pls_checker.sv
tb/pls_list_checker.sv
tb/tb_positional_list_stack.sv
